// File: hw/rtl/leb_pkg.sv
// Shared types, codes and constants of the line edit buffer.
// Used by the interfaces, the controller, the datapath and the checker.
package leb_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;

  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int KIND_W = 2;
  localparam int IDX_W  = 6;
  localparam int CELL_W = 11;
  localparam int ATTR_W = 8;
  localparam int FILL_W = 3;

  // Layout coordinates: a column reaches at most 131, a row at most 32.
  localparam int X_W    = 8;
  localparam int Y_W    = 7;
  localparam int PROD_W = 16;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [FILL_W-1:0] TAB_STEP   = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_LEFT   = 3'd2,
    OP_RIGHT  = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_REDRAW = 3'd5
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_CURSOR = 2'd2
  } kind_e;

  typedef struct packed {
    logic load;
    logic start_shift;
    logic shift_step;
    logic fill_step;
    logic start_del;
    logic del_step;
    logic del_commit;
    logic mv_left;
    logic mv_right;
    logic clear;
    logic rd_start;
    logic walk_step;
    logic out_status;
    logic out_final;
    logic status_acc;
  } leb_cmd_t;

  typedef struct packed {
    logic ins_ok;
    logic del_ok;
    logic left_ok;
    logic right_ok;
    logic clr_acc;
    logic shift_done;
    logic fill_last;
    logic del_done;
    logic walk_end;
    logic out_free;
  } leb_sts_t;

endpackage

// File: hw/rtl/leb_if.sv
// Command and result channel interfaces of the line edit buffer.
// Depends on leb_pkg for the field widths.
interface leb_cmd_if import leb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  origin_row;
  logic [COL_W-1:0]  origin_col;

  modport source (output valid, op, char_code, origin_row, origin_col, input ready);
  modport sink (input valid, op, char_code, origin_row, origin_col, output ready);
endinterface

interface leb_res_if import leb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              accepted;
  logic [IDX_W-1:0]  cursor_index;
  logic [IDX_W-1:0]  text_length;
  logic [CELL_W-1:0] cell_index;
  logic [CHAR_W-1:0] glyph;
  logic [ATTR_W-1:0] attribute;
  logic [ROW_W-1:0]  screen_row;
  logic [COL_W-1:0]  screen_col;
  logic              last;

  modport source (
    output valid, kind, accepted, cursor_index, text_length, cell_index, glyph,
           attribute, screen_row, screen_col, last,
    input  ready
  );
  modport sink (
    input  valid, kind, accepted, cursor_index, text_length, cell_index, glyph,
           attribute, screen_row, screen_col, last,
    output ready
  );
endinterface

// File: hw/rtl/leb_ctrl.sv
// Command sequencer of the line edit buffer.
// Depends on leb_pkg; drives the datapath through leb_cmd_t and reads leb_sts_t.
module leb_ctrl import leb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] op_i,
  input  leb_sts_t        sts_i,
  output logic            in_ready_o,
  output leb_cmd_t        cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SHIFT  = 7'b0000010,
    S_FILL   = 7'b0000100,
    S_DEL    = 7'b0001000,
    S_STATUS = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_FINAL  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   acc_q, acc_d;
  op_e    op;

  assign op         = op_e'(op_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    cmd_o   = '0;
    cmd_o.status_acc = acc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_STATUS;
          acc_d      = 1'b0;
          unique case (op)
            OP_INSERT: begin
              if (sts_i.ins_ok) begin
                cmd_o.start_shift = 1'b1;
                state_d           = S_SHIFT;
              end
            end
            OP_DELETE: begin
              if (sts_i.del_ok) begin
                cmd_o.start_del = 1'b1;
                state_d         = S_DEL;
              end
            end
            OP_LEFT: begin
              cmd_o.mv_left = sts_i.left_ok;
              acc_d         = sts_i.left_ok;
            end
            OP_RIGHT: begin
              cmd_o.mv_right = sts_i.right_ok;
              acc_d          = sts_i.right_ok;
            end
            OP_CLEAR: begin
              cmd_o.clear = 1'b1;
              acc_d       = sts_i.clr_acc;
            end
            OP_REDRAW: begin
              cmd_o.rd_start = 1'b1;
              state_d        = S_WALK;
            end
            default: begin
              acc_d = 1'b0;
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_done) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          acc_d   = 1'b1;
          state_d = S_STATUS;
        end
      end
      S_DEL: begin
        cmd_o.del_step = 1'b1;
        if (sts_i.del_done) begin
          cmd_o.del_commit = 1'b1;
          acc_d            = 1'b1;
          state_d          = S_STATUS;
        end
      end
      S_STATUS: begin
        cmd_o.out_status = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_end) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd_o.out_final = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

endmodule

// File: hw/rtl/leb_datapath.sv
// Text memory, cursor, layout walker and result register of the line edit buffer.
// Depends on leb_pkg; executes the commands of leb_ctrl and reports leb_sts_t.
module leb_datapath import leb_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  input  leb_cmd_t          cmd_i,
  output leb_sts_t          sts_o,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [ROW_W-1:0]  origin_row_i,
  input  logic [COL_W-1:0]  origin_col_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] kind_o,
  output logic              accepted_o,
  output logic [IDX_W-1:0]  cursor_index_o,
  output logic [IDX_W-1:0]  text_length_o,
  output logic [CELL_W-1:0] cell_index_o,
  output logic [CHAR_W-1:0] glyph_o,
  output logic [ATTR_W-1:0] attribute_o,
  output logic [ROW_W-1:0]  screen_row_o,
  output logic [COL_W-1:0]  screen_col_o,
  output logic              last_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [X_W-1:0] WIDTH_X  = X_W'(SCREEN_WIDTH);
  localparam logic [Y_W-1:0] HEIGHT_Y = Y_W'(SCREEN_HEIGHT);
  localparam logic [Y_W-1:0] BOTTOM_Y = Y_W'(SCREEN_HEIGHT - 1);

  logic [CHAR_W-1:0] text_mem_q [CAPACITY];
  logic [CHAR_W-1:0] rd_data_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata;

  logic [AW-1:0]     cursor_q, cursor_d, length_q, length_d, p_q, p_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;
  logic              pend_q, pend_d;
  logic [FILL_W-1:0] fill_cnt_q, fill_cnt_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [X_W-1:0]    scol_q, scol_d, x_q, x_d, tx_q, tx_d;
  logic [Y_W-1:0]    y_q, y_d, ty_q, ty_d;
  logic [ATTR_W-1:0] attr_q;

  logic [AW-1:0]     n_in;
  logic [AW:0]       ins_sum, p_plus;
  logic              del_more, at_cursor, walk_end, emit, advance, out_free;
  logic [X_W-1:0]    x_inc, x_tab4, x_tab, x_nx;
  logic [Y_W-1:0]    y_inc, y_raw;
  logic              load_write, load_any;
  logic [X_W-1:0]    sel_x;
  logic [Y_W-1:0]    sel_y;
  logic [PROD_W-1:0] cell_full;

  logic              out_valid_q;
  kind_e             kind_q;
  logic              acc_q;
  logic [IDX_W-1:0]  cur_out_q, len_out_q;
  logic [CELL_W-1:0] cell_q;
  logic [CHAR_W-1:0] glyph_q;
  logic [ATTR_W-1:0] attr_out_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              last_q;

  // Status toward the sequencer.
  assign n_in     = (char_code_i == CH_TAB) ? AW'(TAB_STEP) : AW'(1);
  assign ins_sum  = {1'b0, length_q} + {1'b0, n_in};
  assign p_plus   = {1'b0, p_q} + (AW + 1)'(1);
  assign del_more = (p_plus < {1'b0, length_q});
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.ins_ok     = (ins_sum < (AW + 1)'(CAPACITY));
  assign sts_o.del_ok     = (cursor_q != '0) && (length_q != '0);
  assign sts_o.left_ok    = (cursor_q != '0);
  assign sts_o.right_ok   = (cursor_q < length_q);
  assign sts_o.clr_acc    = (cursor_q != '0) || (length_q != '0);
  assign sts_o.shift_done = (p_q == cursor_q) && !pend_q;
  assign sts_o.fill_last  = (fill_cnt_q == FILL_W'(1));
  assign sts_o.del_done   = !del_more && !pend_q;
  assign sts_o.walk_end   = walk_end;
  assign sts_o.out_free   = out_free;

  // Layout of the character at the walk position.
  assign at_cursor = (p_q == cursor_q);
  assign walk_end  = (p_q == length_q);
  assign emit      = (rd_data_q != CH_NL) && (rd_data_q != CH_TAB) &&
                     (y_q < HEIGHT_Y) && (x_q < WIDTH_X);
  assign advance   = cmd_i.walk_step && !walk_end && (!emit || out_free);
  assign x_inc     = x_q + X_W'(1);
  assign x_tab4    = x_q + X_W'(TAB_STEP);
  assign x_tab     = {x_tab4[X_W-1:2], 2'b00};
  assign y_inc     = y_q + Y_W'(1);

  always_comb begin
    x_nx  = x_inc;
    y_raw = y_q;
    if (rd_data_q == CH_NL) begin
      x_nx  = scol_q;
      y_raw = y_inc;
    end else if (rd_data_q == CH_TAB) begin
      if (x_tab >= WIDTH_X) begin
        x_nx  = x_tab - WIDTH_X;
        y_raw = y_inc;
      end else begin
        x_nx = x_tab;
      end
    end else if (x_inc >= WIDTH_X) begin
      x_nx  = scol_q;
      y_raw = y_inc;
    end
  end

  always_comb begin
    cursor_d   = cursor_q;
    length_d   = length_q;
    p_d        = p_q;
    pend_d     = pend_q;
    wr_addr_d  = wr_addr_q;
    fill_cnt_d = fill_cnt_q;
    char_d     = char_q;
    scol_d     = scol_q;
    x_d        = x_q;
    y_d        = y_q;
    tx_d       = tx_q;
    ty_d       = ty_q;
    mem_we     = 1'b0;
    mem_waddr  = wr_addr_q;
    mem_wdata  = rd_data_q;
    mem_re     = 1'b0;
    mem_raddr  = p_q;

    if (cmd_i.load) begin
      char_d = char_code_i;
      scol_d = X_W'(origin_col_i);
    end
    if (cmd_i.start_shift) begin
      p_d        = length_q;
      pend_d     = 1'b0;
      fill_cnt_d = (char_code_i == CH_TAB) ? TAB_STEP : FILL_W'(1);
    end
    if (cmd_i.shift_step) begin
      mem_we = pend_q;
      if (p_q != cursor_q) begin
        mem_re    = 1'b1;
        mem_raddr = p_q - AW'(1);
        wr_addr_d = p_q - AW'(1) + AW'(fill_cnt_q);
        p_d       = p_q - AW'(1);
        pend_d    = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end
    if (cmd_i.fill_step) begin
      mem_we     = 1'b1;
      mem_waddr  = cursor_q;
      mem_wdata  = (char_q == CH_TAB) ? CH_SPACE : char_q;
      cursor_d   = cursor_q + AW'(1);
      length_d   = length_q + AW'(1);
      fill_cnt_d = fill_cnt_q - FILL_W'(1);
    end
    if (cmd_i.start_del) begin
      cursor_d = cursor_q - AW'(1);
      p_d      = cursor_q - AW'(1);
      pend_d   = 1'b0;
    end
    if (cmd_i.del_step) begin
      mem_we = pend_q;
      if (del_more) begin
        mem_re    = 1'b1;
        mem_raddr = p_q + AW'(1);
        wr_addr_d = p_q;
        p_d       = p_q + AW'(1);
        pend_d    = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end
    if (cmd_i.del_commit) begin
      length_d = length_q - AW'(1);
    end
    if (cmd_i.mv_left) begin
      cursor_d = cursor_q - AW'(1);
    end
    if (cmd_i.mv_right) begin
      cursor_d = cursor_q + AW'(1);
    end
    if (cmd_i.clear) begin
      cursor_d = '0;
      length_d = '0;
    end
    if (cmd_i.rd_start) begin
      p_d       = '0;
      x_d       = X_W'(origin_col_i);
      y_d       = Y_W'(origin_row_i);
      tx_d      = X_W'(origin_col_i);
      ty_d      = Y_W'(origin_row_i);
      mem_re    = 1'b1;
      mem_raddr = '0;
    end
    if (cmd_i.walk_step && at_cursor) begin
      tx_d = x_q;
      ty_d = y_q;
    end
    if (advance) begin
      x_d       = x_nx;
      y_d       = (y_raw >= HEIGHT_Y) ? BOTTOM_Y : y_raw;
      p_d       = p_q + AW'(1);
      mem_re    = 1'b1;
      mem_raddr = p_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      text_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= text_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q   <= '0;
      length_q   <= '0;
      p_q        <= '0;
      pend_q     <= 1'b0;
      fill_cnt_q <= '0;
      attr_q     <= ATTR_RESET;
    end else begin
      cursor_q   <= cursor_d;
      length_q   <= length_d;
      p_q        <= p_d;
      pend_q     <= pend_d;
      fill_cnt_q <= fill_cnt_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    char_q    <= char_d;
    scol_q    <= scol_d;
    x_q       <= x_d;
    y_q       <= y_d;
    tx_q      <= tx_d;
    ty_q      <= ty_d;
  end

  // Result register.
  assign load_write = advance && emit;
  assign load_any   = cmd_i.out_status || cmd_i.out_final || load_write;
  assign sel_x      = cmd_i.out_final ? tx_q : x_q;
  assign sel_y      = cmd_i.out_final ? ty_q : y_q;
  assign cell_full  = PROD_W'(sel_y) * PROD_W'(SCREEN_WIDTH) + PROD_W'(sel_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_any) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_any) begin
      cur_out_q  <= IDX_W'(cursor_q);
      len_out_q  <= IDX_W'(length_q);
      acc_q      <= 1'b0;
      cell_q     <= cell_full[CELL_W-1:0];
      glyph_q    <= '0;
      attr_out_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      last_q     <= 1'b1;
      priority if (cmd_i.out_status) begin
        kind_q <= KIND_STATUS;
        acc_q  <= cmd_i.status_acc;
        cell_q <= '0;
      end else if (cmd_i.out_final) begin
        kind_q <= KIND_CURSOR;
        row_q  <= ty_q[ROW_W-1:0];
        col_q  <= tx_q[COL_W-1:0];
      end else begin
        kind_q     <= KIND_WRITE;
        glyph_q    <= rd_data_q;
        attr_out_q <= attr_q;
        last_q     <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign accepted_o     = acc_q;
  assign cursor_index_o = cur_out_q;
  assign text_length_o  = len_out_q;
  assign cell_index_o   = cell_q;
  assign glyph_o        = glyph_q;
  assign attribute_o    = attr_out_q;
  assign screen_row_o   = row_q;
  assign screen_col_o   = col_q;
  assign last_o         = last_q;

endmodule

// File: hw/rtl/line_edit_buffer_with_layout_core.sv
// A cursor move, clear or refused command goes from acceptance straight to its status.
// An insert shifts the text from the cursor to the end up by the inserted width, then
// writes the character (four spaces for a tab) and delivers its status; a delete removes
// the character before the cursor, moves the text behind it down by one and then delivers
// its status. A redraw reads one stored character per cycle while the sink does not stall.
// Sink stalls delay results. Reset clears cursor and length, sets the attribute to 7, not text.
module line_edit_buffer_with_layout_core import leb_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  leb_cmd_if.sink           cmd_i,
  leb_res_if.source         res_o
);

  leb_cmd_t cmd;
  leb_sts_t sts;

  leb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .op_i       (cmd_i.op),
    .sts_i      (sts),
    .in_ready_o (cmd_i.ready),
    .cmd_o      (cmd)
  );

  leb_datapath #(
    .CAPACITY      (CAPACITY),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .char_code_i    (cmd_i.char_code),
    .origin_row_i   (cmd_i.origin_row),
    .origin_col_i   (cmd_i.origin_col),
    .out_valid_o    (res_o.valid),
    .out_ready_i    (res_o.ready),
    .kind_o         (res_o.kind),
    .accepted_o     (res_o.accepted),
    .cursor_index_o (res_o.cursor_index),
    .text_length_o  (res_o.text_length),
    .cell_index_o   (res_o.cell_index),
    .glyph_o        (res_o.glyph),
    .attribute_o    (res_o.attribute),
    .screen_row_o   (res_o.screen_row),
    .screen_col_o   (res_o.screen_col),
    .last_o         (res_o.last)
  );

endmodule

// File: hw/rtl/leb_checker.sv
// Port-level checks of the line edit buffer result channel.
// Depends on leb_pkg; bound to line_edit_buffer_with_layout_core below.
module leb_checker import leb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [KIND_W-1:0] kind_i,
  input logic              accepted_i,
  input logic [IDX_W-1:0]  cursor_index_i,
  input logic [IDX_W-1:0]  text_length_i,
  input logic              last_i
);

  // The cursor never points past the end of the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (cursor_index_i <= text_length_i))
    else $error("cursor index beyond text length");

  // Only an edit status can report an accepted command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && accepted_i) |-> (kind_i == KIND_STATUS))
    else $error("accepted flag on a non-status result");

  // Every result that is not a screen write ends its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !last_i) |-> (kind_i == KIND_WRITE))
    else $error("non-final result that is not a screen write");

  // A stalled transfer keeps its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      (res_valid_i && $stable(kind_i) && $stable(last_i) && $stable(cursor_index_i)))
    else $error("result changed while stalled");

endmodule

bind line_edit_buffer_with_layout_core leb_checker u_leb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .kind_i         (res_o.kind),
  .accepted_i     (res_o.accepted),
  .cursor_index_i (res_o.cursor_index),
  .text_length_i  (res_o.text_length),
  .last_i         (res_o.last)
);
